@@ rtl/b64_pkg.sv @@
// ============================================================================
// b64_pkg: shared types, codes and character tables of the Base64 codec
// Holds the command passed from the front end to the back end, the status
// codes, the direction codes and the alphabet mapping functions.
// ============================================================================
`default_nettype none

package b64_pkg;

    // Direction register codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Closing status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    // Characters with a special meaning.
    localparam logic [7:0] CH_PAD = 8'h3D;  // '='
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_UA  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UZ  = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_LA  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LZ  = 8'h7A;  // 'z'
    localparam logic [7:0] CH_D0  = 8'h30;  // '0'
    localparam logic [7:0] CH_D9  = 8'h39;  // '9'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'

    // Sextet boundaries of the alphabet.
    localparam logic [5:0] SX_LOWER = 6'd26;
    localparam logic [5:0] SX_DIGIT = 6'd52;
    localparam logic [5:0] SX_PLUS  = 6'd62;
    localparam logic [5:0] SX_SLASH = 6'd63;

    // One command carries up to four results of a single input item.
    typedef struct packed {
        logic [3:0][7:0] data;     // result bytes, slot 0 first
        logic [1:0]      top_idx;  // index of the final slot
        logic            has;      // results carry data
        logic            last;     // final slot closes the message
        t_status         status;   // status of the final slot
    } t_cmd;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    // Sextet to Base64 character.
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < SX_LOWER) begin
            c = CH_UA + {2'b00, v};
        end else if (v < SX_DIGIT) begin
            c = CH_LA + {2'b00, v - SX_LOWER};
        end else if (v < SX_PLUS) begin
            c = CH_D0 + {2'b00, v - SX_DIGIT};
        end else if (v == SX_PLUS) begin
            c = CH_PLUS;
        end else begin
            c = CH_SLASH;
        end
        return c;
    endfunction

    // Base64 character to sextet; valid is low outside the alphabet.
    function automatic t_sextet dec_sextet(input logic [7:0] c);
        t_sextet s;
        s.valid = 1'b1;
        if (c >= CH_UA && c <= CH_UZ) begin
            s.value = 6'(c - CH_UA);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            s.value = 6'(c - CH_LA) + SX_LOWER;
        end else if (c >= CH_D0 && c <= CH_D9) begin
            s.value = 6'(c - CH_D0) + SX_DIGIT;
        end else if (c == CH_PLUS) begin
            s.value = SX_PLUS;
        end else if (c == CH_SLASH) begin
            s.value = SX_SLASH;
        end else begin
            s.valid = 1'b0;
            s.value = 6'd0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/base64_stream_codec.sv @@
// ============================================================================
// base64_stream_codec: streaming Base64 encoder and decoder
// Standard alphabet codec with a one-bit direction register.
//
// Usage: write the direction on the configuration channel (0 encode bytes to
// text, 1 decode text to bytes) while the block is idle; a write also clears
// the stream state. Input items arrive as stream transactions on the slave
// side, one byte each, with tlast on the final item of a message. Results
// leave on the master side, one per transaction: tdata is the output byte,
// tuser carries has_byte and the closing status, tlast marks the final result.
// The first result of an item passes the command queue and the output
// register before it can leave.
// Throughput: the front end takes one item per cycle while the two-entry
// command queue has room; the back end delivers one result per cycle while
// the receiver is ready, so encoding runs at about four results per three
// bytes and a flush of up to four results leaves one result at a time.
// The output port of the back end sets the sustained rate.
// Reset (synchronous, active low) selects encode and empties the queue.
// When the receiver stalls, the output register holds its result, the queue
// fills and then tready drops; no transaction is lost or repeated.
// ============================================================================
`default_nettype none

module base64_stream_codec (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write channel: bit 0 is the direction.
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_data,
    // Slave side: tdata = in_byte[7:0].
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,
    input  wire logic       i_s_axis_tlast,
    // Master side: tdata = out_byte[7:0]; tuser = has_byte[0], status[2:1].
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,
    output logic            o_m_axis_tlast,
    output logic [2:0]      o_m_axis_tuser
);
    import b64_pkg::*;

    logic w_full;
    logic w_push;
    logic w_head_valid;
    logic w_pop;
    t_cmd w_cmd;
    t_cmd w_head;

    // Configuration writes are always taken; the user writes only when idle.
    assign o_cfg_ready = 1'b1;

    b64_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    // The queue lets the front end keep accepting while results wait.
    b64_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_cmd),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    b64_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast),
        .o_user       (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ rtl/b64_front.sv @@
// ============================================================================
// b64_front: input side of the Base64 codec
// Holds the direction register and the stream state, classifies each input
// item; one that ends a message or causes results makes one command of them.
// ============================================================================
`default_nettype none

module b64_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic          i_cfg_data,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    input  wire logic          i_full,
    output logic               o_push,
    output b64_pkg::t_cmd      o_cmd
);
    import b64_pkg::*;

    logic        r_dir;
    logic [5:0]  r_acc;
    logic [2:0]  r_pend;
    logic        r_err;
    logic        r_any;
    logic [5:0]  n_acc;
    logic [2:0]  n_pend;
    logic        n_err;
    logic        n_any;

    logic        w_accept;
    logic [11:0] w_enc;
    logic [11:0] w_dec;
    logic        w_skip;
    logic        w_have;
    logic [7:0]  w_byte;
    t_sextet     w_sx;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign w_sx     = dec_sextet(i_byte);
    assign w_enc    = {r_acc[3:0], i_byte};
    assign w_dec    = {r_acc, w_sx.value};
    assign w_skip   = (i_byte == CH_PAD) || (i_byte == CH_CR) || (i_byte == CH_LF);

    always_comb begin
        n_acc  = r_acc;
        n_pend = r_pend;
        n_err  = r_err;
        n_any  = r_any;
        w_have = 1'b0;
        w_byte = 8'd0;
        o_push = 1'b0;
        o_cmd  = '0;
        if (r_dir == DIR_ENCODE) begin
            n_acc  = w_enc[5:0];
            o_cmd.has = 1'b1;
            o_push = w_accept;
            unique case (r_pend)
                3'd0: begin
                    n_pend = 3'd2;
                    o_cmd.data[0] = enc_char(w_enc[7:2]);
                    if (i_last) begin
                        o_cmd.data[1] = enc_char({w_enc[1:0], 4'b0000});
                        o_cmd.data[2] = CH_PAD;
                        o_cmd.data[3] = CH_PAD;
                        o_cmd.top_idx = 2'd3;
                    end
                end
                3'd2: begin
                    n_pend = 3'd4;
                    o_cmd.data[0] = enc_char(w_enc[9:4]);
                    if (i_last) begin
                        o_cmd.data[1] = enc_char({w_enc[3:0], 2'b00});
                        o_cmd.data[2] = CH_PAD;
                        o_cmd.top_idx = 2'd2;
                    end
                end
                default: begin
                    n_pend = 3'd0;
                    o_cmd.data[0] = enc_char(w_enc[11:6]);
                    o_cmd.data[1] = enc_char(w_enc[5:0]);
                    o_cmd.top_idx = 2'd1;
                end
            endcase
            o_cmd.last   = i_last;
            o_cmd.status = ST_OK;
        end else begin
            if (!r_err && !w_skip) begin
                if (!w_sx.valid) begin
                    n_err = 1'b1;
                end else begin
                    n_acc = w_dec[5:0];
                    unique case (r_pend)
                        3'd0: n_pend = 3'd6;
                        3'd2: begin
                            n_pend = 3'd0;
                            w_have = 1'b1;
                            w_byte = w_dec[7:0];
                        end
                        3'd4: begin
                            n_pend = 3'd2;
                            w_have = 1'b1;
                            w_byte = w_dec[9:2];
                        end
                        default: begin
                            n_pend = 3'd4;
                            w_have = 1'b1;
                            w_byte = w_dec[11:4];
                        end
                    endcase
                    n_any = r_any || w_have;
                end
            end
            o_cmd.data[0] = w_byte;
            o_cmd.has     = w_have;
            o_cmd.last    = i_last;
            o_cmd.top_idx = 2'd0;
            if (i_last) begin
                o_cmd.status = n_err ? ST_INVALID : (n_any ? ST_OK : ST_EMPTY);
            end else begin
                o_cmd.status = ST_OK;
            end
            o_push = w_accept && (i_last || w_have);
        end
        // A message end returns the stream state to zero.
        if (i_last) begin
            n_acc  = 6'd0;
            n_pend = 3'd0;
            n_err  = 1'b0;
            n_any  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIR_ENCODE;
            r_acc  <= 6'd0;
            r_pend <= 3'd0;
            r_err  <= 1'b0;
            r_any  <= 1'b0;
        end else if (i_cfg_valid) begin
            r_dir  <= i_cfg_data;
            r_acc  <= 6'd0;
            r_pend <= 3'd0;
            r_err  <= 1'b0;
            r_any  <= 1'b0;
        end else if (w_accept) begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
            r_err  <= n_err;
            r_any  <= n_any;
        end
    end

endmodule

`default_nettype wire

@@ rtl/b64_queue.sv @@
// ============================================================================
// b64_queue: two-entry command queue
// Decouples the front end from the back end so that each can stall alone.
// ============================================================================
`default_nettype none

module b64_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire b64_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_head_valid,
    output b64_pkg::t_cmd      o_head,
    input  wire logic          i_pop
);
    import b64_pkg::*;

    localparam int DEPTH = 2;

    t_cmd       r_mem [DEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full       = (r_count == 2'(DEPTH));
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ rtl/b64_back.sv @@
// ============================================================================
// b64_back: output side of the Base64 codec
// Walks the slots of the head command and delivers one result per cycle
// while the receiver is ready, through a registered output stage.
// ============================================================================
`default_nettype none

module b64_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_head_valid,
    input  wire b64_pkg::t_cmd i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_data,
    output logic               o_last,
    output logic [2:0]         o_user
);
    import b64_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic [2:0] r_user;
    logic       w_load;
    logic       w_final;

    assign w_load  = i_head_valid && (!r_valid || i_ready);
    assign w_final = (r_idx == i_head.top_idx);
    assign o_pop   = w_load && w_final;

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_user  = r_user;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_head.data[r_idx];
            r_last <= i_head.last && w_final;
            r_user <= {(w_final ? i_head.status : ST_OK), i_head.has};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_final ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_user[0]) |-> r_last)
        else $error("result without data that does not close the message");

    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_user[2:1] != ST_OK)) |-> r_last)
        else $error("nonzero status outside the closing result");

    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_idx <= i_head.top_idx))
        else $error("slot index beyond the head command");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ============================================================================
// tb_top: self-checking testbench of the Base64 stream codec
// Runs a table of directed items through both directions, then random
// messages: raw bytes for encoding, well-formed Base64 text with random line
// breaks and padding for decoding, plus noise and corrupted text. Every
// accepted input transaction is run through a cycle-free predictor of the
// codec; every output transaction is compared field by field against the
// oldest predicted result. Both stream sides idle and stall at random.
// ============================================================================

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b64_pkg::*;

    // ------------------------------------------------------------------------
    // Types and constants
    // ------------------------------------------------------------------------

    // One output transaction as the codec produces it.
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        t_status    status;
    } t_codec_result;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // One directed step. Typed rows carry their own results; the others are
    // checked against the predictor.
    typedef struct packed {
        t_row_kind                kind;
        logic [7:0]               value;
        logic                     last;
        logic                     typed;
        logic [2:0]               n_exp;
        t_codec_result [0:3]      exp;
    } t_stim_row;

    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    localparam int RANDOM_ITEMS = 320;
    // A result passes the command queue and the output register before it can be
    // taken; the drain pause leaves generous room beyond that.
    localparam int DRAIN_CYCLES = 8;

    localparam t_codec_result RS_A         = '{CH_UA,    1'b1, 1'b0, ST_OK};
    localparam t_codec_result RS_PAD       = '{CH_PAD,   1'b1, 1'b0, ST_OK};
    localparam t_codec_result RS_PAD_END   = '{CH_PAD,   1'b1, 1'b1, ST_OK};
    localparam t_codec_result RS_SLASH     = '{CH_SLASH, 1'b1, 1'b0, ST_OK};
    localparam t_codec_result RS_SLASH_END = '{CH_SLASH, 1'b1, 1'b1, ST_OK};
    localparam t_codec_result RS_CLOSE_OK  = '{8'h00,    1'b0, 1'b1, ST_OK};
    localparam t_codec_result RS_CLOSE_BAD = '{8'h00,    1'b0, 1'b1, ST_INVALID};
    localparam t_codec_result RS_CLOSE_NIL = '{8'h00,    1'b0, 1'b1, ST_EMPTY};
    localparam t_codec_result [0:3] NO_EXP = '0;

    localparam int N_DIRECTED = 29;
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // Encode straight out of reset: one zero byte flushes as "AA==".
        '{ROW_ITEM, 8'h00, 1'b1, 1'b1, 3'd4, {RS_A, RS_A, RS_PAD, RS_PAD_END}},
        // All ones: a full group of three bytes, no padding.
        '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, 3'd2, {RS_SLASH, RS_SLASH_END, RS_A, RS_A}},
        // Two bytes leave four bits pending: flush with a single pad.
        '{ROW_ITEM, "M",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "a",   1'b1, 1'b0, 3'd0, NO_EXP},
        '{ROW_CFG,  {7'd0, DIR_DECODE}, 1'b0, 1'b0, 3'd0, NO_EXP},
        // A message of padding only decodes to nothing.
        '{ROW_ITEM, CH_PAD, 1'b1, 1'b1, 3'd1, {RS_CLOSE_NIL, RS_A, RS_A, RS_A}},
        // Plain text; the last character completes the third byte.
        '{ROW_ITEM, "T",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "W",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "F",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "u",   1'b1, 1'b0, 3'd0, NO_EXP},
        // An invalid character silences the rest of the message.
        '{ROW_ITEM, "A",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "#",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "B",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "C",   1'b1, 1'b1, 3'd1, {RS_CLOSE_BAD, RS_A, RS_A, RS_A}},
        // Line breaks are skipped; a trailing pad closes with a bare result.
        '{ROW_ITEM, CH_CR, 1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, CH_LF, 1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "/",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "/",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, CH_PAD, 1'b1, 1'b1, 3'd1, {RS_CLOSE_OK, RS_A, RS_A, RS_A}},
        // Top byte value as a character is invalid.
        '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, 3'd1, {RS_CLOSE_BAD, RS_A, RS_A, RS_A}},
        // Leftover bits at the close are dropped without error.
        '{ROW_ITEM, "Q",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "Q",   1'b1, 1'b0, 3'd0, NO_EXP},
        // The other alphabet corners: '+', 'z', '9', 'a'.
        '{ROW_ITEM, "+",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "z",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "9",   1'b0, 1'b0, 3'd0, NO_EXP},
        '{ROW_ITEM, "a",   1'b1, 1'b0, 3'd0, NO_EXP},
        '{ROW_CFG,  {7'd0, DIR_ENCODE}, 1'b0, 1'b0, 3'd0, NO_EXP}
    };

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_valid     = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data      = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = 8'h00;
    logic       i_s_axis_tlast  = 1'b0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;
    logic [2:0] o_m_axis_tuser;

    always #10 i_clk = ~i_clk;

    base64_stream_codec u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // in_byte[7:0]
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // out_byte[7:0]
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)    // has_byte[0], status[2:1]
    );

    // ------------------------------------------------------------------------
    // Codec predictor
    // ------------------------------------------------------------------------

    logic          dir_q;
    logic [15:0]   acc_bits;
    logic [3:0]    acc_count;
    logic          bad_char_seen;
    logic          byte_emitted;
    t_codec_result step_out[$];
    t_codec_result expected_q[$];
    int            fail_count = 0;

    function automatic void clear_stream_model();
        acc_bits      = '0;
        acc_count     = '0;
        bad_char_seen = 1'b0;
        byte_emitted  = 1'b0;
    endfunction

    function automatic int alphabet_index(input logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (ALPHABET[i] == c) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_codec_result result_of(input logic [7:0] d, input logic h,
                                                input logic l, input t_status st);
        t_codec_result r;
        r.data   = d;
        r.has    = h;
        r.last   = l;
        r.status = st;
        return r;
    endfunction

    // Works out the results that one input transaction causes into step_out.
    function automatic void predict_codec(input logic [7:0] b, input logic l);
        int         v;
        logic [7:0] dec_byte;
        logic       have;
        t_status    st;
        step_out.delete();
        if (dir_q == DIR_ENCODE) begin
            acc_bits  = {acc_bits[7:0], b};
            acc_count = acc_count + 4'd8;
            while (acc_count >= 4'd6) begin
                acc_count = acc_count - 4'd6;
                v = (int'(acc_bits) >> acc_count) & 63;
                step_out = {step_out, result_of(ALPHABET[v], 1'b1,
                                                l && acc_count == 4'd0, ST_OK)};
            end
            // Flush: the leftover bits are zero-filled on the right, then
            // the group is padded out to four characters.
            if (l && acc_count != 4'd0) begin
                v = (int'(acc_bits) << (6 - int'(acc_count))) & 63;
                step_out = {step_out, result_of(ALPHABET[v], 1'b1, 1'b0, ST_OK)};
                step_out = {step_out, result_of(CH_PAD, 1'b1, acc_count == 4'd4, ST_OK)};
                if (acc_count == 4'd2) begin
                    step_out = {step_out, result_of(CH_PAD, 1'b1, 1'b1, ST_OK)};
                end
            end
        end else begin
            have     = 1'b0;
            dec_byte = 8'h00;
            if (!bad_char_seen && b != CH_PAD && b != CH_CR && b != CH_LF) begin
                v = alphabet_index(b);
                if (v < 0) begin
                    bad_char_seen = 1'b1;
                end else begin
                    acc_bits  = {acc_bits[9:0], 6'(v)};
                    acc_count = acc_count + 4'd6;
                    if (acc_count >= 4'd8) begin
                        acc_count    = acc_count - 4'd8;
                        dec_byte     = 8'(acc_bits >> acc_count);
                        have         = 1'b1;
                        byte_emitted = 1'b1;
                    end
                end
            end
            if (l) begin
                if (bad_char_seen) begin
                    st = ST_INVALID;
                end else if (byte_emitted) begin
                    st = ST_OK;
                end else begin
                    st = ST_EMPTY;
                end
                step_out = {step_out, result_of(dec_byte, have, 1'b1, st)};
            end else if (have) begin
                step_out = {step_out, result_of(dec_byte, 1'b1, 1'b0, ST_OK)};
            end
        end
        if (l) begin
            clear_stream_model();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random backpressure and the result checker
    // ------------------------------------------------------------------------

    int sink_hold = 0;

    // Mostly long ready stretches with short stalls between them, and now
    // and then a long stall that backs the queue up into the input side.
    always @(posedge i_clk) begin : sink_pacing
        int r;
        if (sink_hold != 0) begin
            sink_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                i_m_axis_tready <= 1'b1;
                sink_hold = $urandom_range(0, 24);
            end else if (r < 88) begin
                i_m_axis_tready <= 1'b0;
                sink_hold = $urandom_range(0, 2);
            end else if (r < 98) begin
                i_m_axis_tready <= 1'b0;
                sink_hold = $urandom_range(3, 9);
            end else begin
                i_m_axis_tready <= 1'b0;
                sink_hold = $urandom_range(20, 40);
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_codec_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected output transaction: data 0x%0h user 0x%0h last %0b",
                       o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("out_byte", want.data,   o_m_axis_tdata);
                check_field("has_byte", want.has,    o_m_axis_tuser[0]);
                check_field("out_last", want.last,   o_m_axis_tlast);
                check_field("status",   want.status, o_m_axis_tuser[2:1]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 2);
        end else if (r < 97) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(15, 30);
    endfunction

    // Presents one item and returns at the edge of its transaction, with the
    // predicted results left in step_out. Called right after an edge, so
    // tvalid gets one assignment per time step and stays high between
    // back-to-back items.
    task automatic send_item(input logic [7:0] b, input logic l, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= l;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_codec(b, l);
    endtask

    task automatic queue_step_out();
        foreach (step_out[k]) begin
            expected_q = {expected_q, step_out[k]};
        end
    endtask

    // Waits until every predicted result has left, then lets any item that
    // causes no result clear the pipeline.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_direction(input logic d);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        dir_q = d;
        clear_stream_model();
    endtask

    // ------------------------------------------------------------------------
    // Random message builders
    // ------------------------------------------------------------------------

    logic [7:0] msg_q[$];

    task automatic make_encode_msg();
        int n;
        msg_q.delete();
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        repeat (n) msg_q = {msg_q, 8'($urandom_range(0, 255))};
    endtask

    // Mostly proper Base64 text of random bytes, sometimes without padding
    // or with line breaks; some messages get one invalid character and a few
    // are pure noise.
    task automatic make_decode_msg();
        int         n;
        int         r;
        int         acc;
        int         cnt;
        int         pos;
        logic [7:0] c;
        msg_q.delete();
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 8)) msg_q = {msg_q, 8'($urandom_range(0, 255))};
            return;
        end
        n   = $urandom_range(1, 9);
        acc = 0;
        cnt = 0;
        repeat (n) begin
            acc = ((acc << 8) | $urandom_range(0, 255)) & 16'hFFFF;
            cnt += 8;
            while (cnt >= 6) begin
                cnt -= 6;
                msg_q = {msg_q, 8'(ALPHABET[(acc >> cnt) & 63])};
            end
        end
        if (cnt != 0) begin
            msg_q = {msg_q, 8'(ALPHABET[(acc << (6 - cnt)) & 63])};
            if ($urandom_range(0, 3) != 0) begin
                msg_q = {msg_q, CH_PAD};
                if (cnt == 2) begin
                    msg_q = {msg_q, CH_PAD};
                end
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            msg_q.insert($urandom_range(0, msg_q.size()), CH_LF);
        end
        if ($urandom_range(0, 5) == 0) begin
            msg_q.insert($urandom_range(0, msg_q.size()), CH_CR);
        end
        if (r < 25) begin
            pos = $urandom_range(0, msg_q.size() - 1);
            do begin
                c = 8'($urandom_range(0, 255));
            end while (alphabet_index(c) >= 0 || c == CH_PAD || c == CH_CR || c == CH_LF);
            msg_q[pos] = c;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        int   random_items;
        logic d;
        bit   no_gaps;
        bit   open_end;

        dir_q = DIR_ENCODE;
        clear_stream_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Typed rows replace the predicted results with the
        // ones written in the row, but the predictor still runs to keep its
        // state in step.
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                write_direction(DIRECTED[i].value[0]);
            end else begin
                send_item(DIRECTED[i].value, DIRECTED[i].last, 1'b0);
                if (DIRECTED[i].typed) begin
                    for (int k = 0; k < int'(DIRECTED[i].n_exp); k++) begin
                        expected_q = {expected_q, DIRECTED[i].exp[k]};
                    end
                end else begin
                    queue_step_out();
                end
            end
        end

        // Random phases, each under a fresh direction write. Now and then a
        // message is left open so the write has to clear a live stream.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            d = 1'($urandom_range(0, 1));
            write_direction(d);
            repeat ($urandom_range(2, 6)) begin
                if (d == DIR_ENCODE) begin
                    make_encode_msg();
                end else begin
                    make_decode_msg();
                end
                no_gaps  = ($urandom_range(0, 4) == 0);
                open_end = ($urandom_range(0, 9) == 0);
                foreach (msg_q[k]) begin
                    send_item(msg_q[k], (k == msg_q.size() - 1) && !open_end, no_gaps);
                    queue_step_out();
                end
                random_items += msg_q.size();
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // A correct run needs well under a tenth of this.
    initial begin : watchdog
        #20_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
